/* design/pgmhp_pkg.sv */
package pgmhp_pkg;

	localparam int DIM_BITS = 24;
	// A field times ten plus a digit needs four more bits than the field itself.
	localparam int ACC_W    = DIM_BITS + 4;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [DIM_BITS-1:0] MAX_DIM_RESET = DIM_BITS'(1000000);

	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_SP   = 8'h20;

	localparam logic [3:0] DIGIT_FIVE = 4'd5;

	typedef enum logic [2:0] {
		CLS_P,
		CLS_DIGIT,
		CLS_HASH,
		CLS_LF,
		CLS_SPACE,
		CLS_OTHER
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [3:0] digit;
		logic       restart;
	} token_t;

	typedef enum logic [3:0] {
		ST_START    = 4'd0,
		ST_GOT_P    = 4'd1,
		ST_GAP0     = 4'd2,
		ST_GAP1     = 4'd3,
		ST_GAP2     = 4'd4,
		ST_FIELD0   = 4'd6,
		ST_FIELD1   = 4'd7,
		ST_FIELD2   = 4'd8,
		ST_NOTE0    = 4'd9,
		ST_NOTE1    = 4'd10,
		ST_NOTE2    = 4'd11,
		ST_NOTE_END = 4'd12,
		ST_HALT     = 4'd13
	} state_t;

	typedef enum logic [1:0] {
		STAT_BUSY = 2'd0,
		STAT_DONE = 2'd1,
		STAT_INV  = 2'd2,
		STAT_OVF  = 2'd3
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [DIM_BITS-1:0] width;
		logic [DIM_BITS-1:0] height;
		logic [DIM_BITS-1:0] depth;
	} result_t;

endpackage

/* design/pgm_header_parser.sv */
// A pushed word is written into the queue, then parsed into the result register once
// the result slot is free. Throughput: one word per cycle while results are popped,
// limited by the single parse step in the back end.
// A four-word queue between classifier and parser absorbs result-side stalls.
// Reset (arst_n low, asynchronous): parser returns to the start state, queue and
// result slot empty, max_dimension back to 1000000; parsed values are not cleared.
module pgm_header_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     data_byte,
	input  logic                           restart,
	input  logic                           pop,
	output logic                           empty,
	output logic [1:0]                     status,
	output logic [pgmhp_pkg::DIM_BITS-1:0] width,
	output logic [pgmhp_pkg::DIM_BITS-1:0] height,
	output logic [pgmhp_pkg::DIM_BITS-1:0] depth,
	input  logic                           max_dimension_we,
	input  logic [pgmhp_pkg::DIM_BITS-1:0] max_dimension
);

	logic               q_wr;
	logic               q_full;
	logic               q_valid;
	logic               q_take;
	logic               res_valid;
	pgmhp_pkg::token_t  q_in;
	pgmhp_pkg::token_t  q_out;
	pgmhp_pkg::result_t res;

	pgmhp_front u_front (
		.push      (push),
		.data_byte (data_byte),
		.restart   (restart),
		.q_full    (q_full),
		.q_wr      (q_wr),
		.q_data    (q_in)
	);

	pgmhp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_wr),
		.wr_data  (q_in),
		.full     (q_full),
		.rd_en    (q_take),
		.rd_valid (q_valid),
		.rd_data  (q_out)
	);

	pgmhp_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (max_dimension_we),
		.cfg_data  (max_dimension),
		.tok_valid (q_valid),
		.tok       (q_out),
		.tok_take  (q_take),
		.out_pop   (pop && !empty),
		.out_valid (res_valid),
		.out_data  (res)
	);

	assign full   = q_full;
	assign empty  = !res_valid;
	assign status = res.status;
	assign width  = res.width;
	assign height = res.height;
	assign depth  = res.depth;

	// Only a done result carries dimensions.
	a_zero_unless_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.status != pgmhp_pkg::STAT_DONE) |-> (width == '0 && height == '0
			&& depth == '0))
		else $error("dimensions nonzero on a result that is not done");

	// A queued word moves into a free result slot without delay.
	a_no_idle_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && empty) |=> !empty)
		else $error("queued word not parsed while result slot was free");

	// A restart word other than P is rejected at once.
	a_restart_bad_letter: assert property (@(posedge clk) disable iff (!arst_n)
		(q_take && q_out.restart && q_out.cls != pgmhp_pkg::CLS_P)
			|=> (!empty && status == pgmhp_pkg::STAT_INV))
		else $error("restart word without P not reported invalid");

endmodule

/* design/pgmhp_front.sv */
module pgmhp_front (
	input  logic              push,
	input  logic [7:0]        data_byte,
	input  logic              restart,
	input  logic              q_full,
	output logic              q_wr,
	output pgmhp_pkg::token_t q_data
);

	always_comb begin
		q_wr           = push && !q_full;
		q_data.restart = restart;
		q_data.digit   = 4'(data_byte - pgmhp_pkg::CH_ZERO);
		if (data_byte == pgmhp_pkg::CH_P) begin
			q_data.cls = pgmhp_pkg::CLS_P;
		end else if (data_byte >= pgmhp_pkg::CH_ZERO && data_byte <= pgmhp_pkg::CH_NINE) begin
			q_data.cls = pgmhp_pkg::CLS_DIGIT;
		end else if (data_byte == pgmhp_pkg::CH_HASH) begin
			q_data.cls = pgmhp_pkg::CLS_HASH;
		end else if (data_byte == pgmhp_pkg::CH_LF) begin
			q_data.cls = pgmhp_pkg::CLS_LF;
		end else if (data_byte == pgmhp_pkg::CH_SP || data_byte == pgmhp_pkg::CH_TAB
				|| data_byte == pgmhp_pkg::CH_CR) begin
			q_data.cls = pgmhp_pkg::CLS_SPACE;
		end else begin
			q_data.cls = pgmhp_pkg::CLS_OTHER;
		end
	end

endmodule

/* design/pgmhp_queue.sv */
module pgmhp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  pgmhp_pkg::token_t wr_data,
	output logic              full,
	input  logic              rd_en,
	output logic              rd_valid,
	output pgmhp_pkg::token_t rd_data
);

	pgmhp_pkg::token_t                  mem_q [pgmhp_pkg::QDEPTH];
	logic [pgmhp_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [pgmhp_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [pgmhp_pkg::QCNT_W-1:0]       count_q;

	assign full     = (count_q == pgmhp_pkg::QCNT_W'(pgmhp_pkg::QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + pgmhp_pkg::QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + pgmhp_pkg::QPTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + pgmhp_pkg::QCNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - pgmhp_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

/* design/pgmhp_exec.sv */
module pgmhp_exec (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pgmhp_pkg::DIM_BITS-1:0]     cfg_data,
	input  logic                               tok_valid,
	input  pgmhp_pkg::token_t                  tok,
	output logic                               tok_take,
	input  logic                               out_pop,
	output logic                               out_valid,
	output pgmhp_pkg::result_t                 out_data
);

	pgmhp_pkg::state_t                   state_q;
	pgmhp_pkg::state_t                   s;
	pgmhp_pkg::state_t                   nstate;
	pgmhp_pkg::status_t                  nstat;
	logic [pgmhp_pkg::DIM_BITS-1:0]      max_dim_q;
	logic [pgmhp_pkg::DIM_BITS-1:0]      width_q;
	logic [pgmhp_pkg::DIM_BITS-1:0]      height_q;
	logic [pgmhp_pkg::DIM_BITS-1:0]      depth_q;
	logic [pgmhp_pkg::DIM_BITS-1:0]      cur;
	logic [pgmhp_pkg::ACC_W-1:0]         acc;
	logic [pgmhp_pkg::ACC_W-1:0]         first;
	logic                                acc_over;
	logic                                first_over;
	logic [1:0]                          k;
	logic                                val_we;
	logic [pgmhp_pkg::DIM_BITS-1:0]      val_wdata;
	logic                                out_valid_q;
	pgmhp_pkg::result_t                  out_q;

	assign tok_take  = tok_valid && (!out_valid_q || out_pop);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		s = tok.restart ? pgmhp_pkg::ST_START : state_q;

		// Field index within the gap, field and comment groups.
		case (s) inside
			pgmhp_pkg::ST_GAP1, pgmhp_pkg::ST_FIELD1, pgmhp_pkg::ST_NOTE1: k = 2'd1;
			pgmhp_pkg::ST_GAP2, pgmhp_pkg::ST_FIELD2, pgmhp_pkg::ST_NOTE2: k = 2'd2;
			default: k = 2'd0;
		endcase

		case (k)
			2'd0:    cur = width_q;
			2'd1:    cur = height_q;
			default: cur = depth_q;
		endcase

		acc = {1'b0, cur, 3'b000} + {3'b000, cur, 1'b0} + pgmhp_pkg::ACC_W'(tok.digit);
		first = pgmhp_pkg::ACC_W'(tok.digit);
		acc_over   = acc > pgmhp_pkg::ACC_W'(max_dim_q);
		first_over = first > pgmhp_pkg::ACC_W'(max_dim_q);

		nstate    = pgmhp_pkg::ST_HALT;
		nstat     = pgmhp_pkg::STAT_INV;
		val_we    = 1'b0;
		val_wdata = pgmhp_pkg::DIM_BITS'(tok.digit);

		unique case (s) inside
			pgmhp_pkg::ST_START: begin
				if (tok.cls == pgmhp_pkg::CLS_P) begin
					nstate = pgmhp_pkg::ST_GOT_P;
					nstat  = pgmhp_pkg::STAT_BUSY;
				end
			end
			pgmhp_pkg::ST_GOT_P: begin
				if (tok.cls == pgmhp_pkg::CLS_DIGIT && tok.digit == pgmhp_pkg::DIGIT_FIVE) begin
					nstate = pgmhp_pkg::ST_GAP0;
					nstat  = pgmhp_pkg::STAT_BUSY;
				end
			end
			pgmhp_pkg::ST_GAP0, pgmhp_pkg::ST_GAP1, pgmhp_pkg::ST_GAP2: begin
				case (tok.cls) inside
					pgmhp_pkg::CLS_DIGIT: begin
						// The stored value is written even when it overflows.
						val_we    = 1'b1;
						val_wdata = pgmhp_pkg::DIM_BITS'(tok.digit);
						if (first_over) begin
							nstat = pgmhp_pkg::STAT_OVF;
						end else begin
							nstate = pgmhp_pkg::state_t'(4'(pgmhp_pkg::ST_FIELD0) + 4'(k));
							nstat  = pgmhp_pkg::STAT_BUSY;
						end
					end
					pgmhp_pkg::CLS_LF, pgmhp_pkg::CLS_SPACE: begin
						nstate = s;
						nstat  = pgmhp_pkg::STAT_BUSY;
					end
					pgmhp_pkg::CLS_HASH: begin
						nstate = pgmhp_pkg::state_t'(4'(pgmhp_pkg::ST_NOTE0) + 4'(k));
						nstat  = pgmhp_pkg::STAT_BUSY;
					end
					default: begin
						nstate = pgmhp_pkg::ST_HALT;
						nstat  = pgmhp_pkg::STAT_INV;
					end
				endcase
			end
			pgmhp_pkg::ST_FIELD0, pgmhp_pkg::ST_FIELD1, pgmhp_pkg::ST_FIELD2: begin
				case (tok.cls) inside
					pgmhp_pkg::CLS_DIGIT: begin
						if (acc_over) begin
							nstat = pgmhp_pkg::STAT_OVF;
						end else begin
							val_we    = 1'b1;
							val_wdata = pgmhp_pkg::DIM_BITS'(acc);
							nstate    = s;
							nstat     = pgmhp_pkg::STAT_BUSY;
						end
					end
					pgmhp_pkg::CLS_LF, pgmhp_pkg::CLS_SPACE: begin
						if (k == 2'd2) begin
							nstat = pgmhp_pkg::STAT_DONE;
						end else begin
							nstate = pgmhp_pkg::state_t'(4'(pgmhp_pkg::ST_GAP0) + 4'(k) + 4'd1);
							nstat  = pgmhp_pkg::STAT_BUSY;
						end
					end
					pgmhp_pkg::CLS_HASH: begin
						nstat = pgmhp_pkg::STAT_BUSY;
						if (k == 2'd2) begin
							nstate = pgmhp_pkg::ST_NOTE_END;
						end else begin
							nstate = pgmhp_pkg::state_t'(4'(pgmhp_pkg::ST_NOTE0) + 4'(k) + 4'd1);
						end
					end
					default: begin
						nstate = pgmhp_pkg::ST_HALT;
						nstat  = pgmhp_pkg::STAT_INV;
					end
				endcase
			end
			pgmhp_pkg::ST_NOTE0, pgmhp_pkg::ST_NOTE1, pgmhp_pkg::ST_NOTE2: begin
				nstat = pgmhp_pkg::STAT_BUSY;
				if (tok.cls == pgmhp_pkg::CLS_LF) begin
					nstate = pgmhp_pkg::state_t'(4'(pgmhp_pkg::ST_GAP0) + 4'(k));
				end else begin
					nstate = s;
				end
			end
			pgmhp_pkg::ST_NOTE_END: begin
				if (tok.cls == pgmhp_pkg::CLS_LF) begin
					nstat = pgmhp_pkg::STAT_DONE;
				end else begin
					nstate = s;
					nstat  = pgmhp_pkg::STAT_BUSY;
				end
			end
			default: begin
				nstate = pgmhp_pkg::ST_HALT;
				nstat  = pgmhp_pkg::STAT_INV;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pgmhp_pkg::ST_START;
			max_dim_q   <= pgmhp_pkg::MAX_DIM_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_dim_q <= cfg_data;
			end
			if (tok_take) begin
				state_q     <= nstate;
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_take) begin
			if (val_we) begin
				case (k)
					2'd0:    width_q  <= val_wdata;
					2'd1:    height_q <= val_wdata;
					default: depth_q  <= val_wdata;
				endcase
			end
			out_q.status <= nstat;
			if (nstat == pgmhp_pkg::STAT_DONE) begin
				out_q.width  <= width_q;
				out_q.height <= height_q;
				out_q.depth  <= depth_q;
			end else begin
				out_q.width  <= '0;
				out_q.height <= '0;
				out_q.depth  <= '0;
			end
		end
	end

endmodule
